// ----- src/assert_macros.svh -----
// Assertion helpers; expect clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property holds at every clock outside reset.
`define ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Antecedent implies consequent in the same cycle.
`define ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ----- src/rayaabb_pkg.sv -----
package rayaabb_pkg;

    localparam int CoordW = 32;
    localparam int FracW  = 16;
    localparam int MagW   = CoordW + 1;      // |bound - org|
    localparam int NumW   = MagW + FracW;    // dividend, also quotient bits
    localparam int Axes   = 3;
    localparam int Lanes  = 2 * Axes;

    localparam logic [NumW:0] PosLim = (NumW+1)'((64'd1 << (CoordW-1)) - 64'd1);
    localparam logic [NumW:0] NegLim = (NumW+1)'(64'd1 << (CoordW-1));
    localparam logic [CoordW-1:0] TMax = {1'b0, {(CoordW-1){1'b1}}};
    localparam logic [CoordW-1:0] TMin = {1'b1, {(CoordW-1){1'b0}}};

    typedef struct packed {
        logic signed [CoordW-1:0] ray_org_x;
        logic signed [CoordW-1:0] ray_org_y;
        logic signed [CoordW-1:0] ray_org_z;
        logic signed [CoordW-1:0] ray_dir_x;
        logic signed [CoordW-1:0] ray_dir_y;
        logic signed [CoordW-1:0] ray_dir_z;
        logic signed [CoordW-1:0] box_ctr_x;
        logic signed [CoordW-1:0] box_ctr_y;
        logic signed [CoordW-1:0] box_ctr_z;
        logic [CoordW-2:0]        box_half_x;
        logic [CoordW-2:0]        box_half_y;
        logic [CoordW-2:0]        box_half_z;
    } ray_t;

    typedef struct packed {
        logic                     hit;
        logic signed [CoordW-1:0] t_near;
        logic signed [CoordW-1:0] t_far;
    } res_t;

    typedef struct packed {
        logic             miss;
        logic [Axes-1:0]  skip;
        logic [Lanes-1:0] neg;
    } side_t;

    typedef struct packed {
        logic [CoordW-1:0] rem;
        logic [NumW-1:0]   num;
        logic [NumW-1:0]   quo;
        logic [CoordW-1:0] den;
    } lane_t;

    typedef struct packed {
        side_t             side;
        lane_t [Lanes-1:0] lane;
    } div_t;

    typedef struct packed {
        side_t                         side;
        logic [Lanes-1:0][CoordW-1:0]  t;
    } rnd_t;

endpackage

// ----- src/rayaabb_prep.sv -----
module rayaabb_prep import rayaabb_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic up_valid,
    output logic up_ready,
    input  ray_t up_data,
    output logic dn_valid,
    input  logic dn_ready,
    output div_t dn_data
);

    logic valid_reg;
    div_t data_reg;
    div_t data_next;

    logic [Axes-1:0][CoordW-1:0] org, dir, ctr;
    logic [Axes-1:0][CoordW-2:0] half;

    assign org  = {up_data.ray_org_z, up_data.ray_org_y, up_data.ray_org_x};
    assign dir  = {up_data.ray_dir_z, up_data.ray_dir_y, up_data.ray_dir_x};
    assign ctr  = {up_data.box_ctr_z, up_data.box_ctr_y, up_data.box_ctr_x};
    assign half = {up_data.box_half_z, up_data.box_half_y, up_data.box_half_x};

    always_comb
    begin
        logic signed [CoordW+1:0] o, lo, hi, d1, d2;
        logic [CoordW+1:0]        m1, m2;
        logic [CoordW-1:0]        dm;
        logic                     dz;
        data_next = '0;
        for (int a = 0; a < Axes; a++)
        begin
            o  = $signed({{2{org[a][CoordW-1]}}, org[a]});
            lo = $signed({{2{ctr[a][CoordW-1]}}, ctr[a]}) - $signed({3'b000, half[a]});
            hi = $signed({{2{ctr[a][CoordW-1]}}, ctr[a]}) + $signed({3'b000, half[a]});
            d1 = lo - o;
            d2 = hi - o;
            m1 = d1[CoordW+1] ? -d1 : d1;
            m2 = d2[CoordW+1] ? -d2 : d2;
            dm = dir[a][CoordW-1] ? -dir[a] : dir[a];
            dz = (dir[a] == '0);
            data_next.side.skip[a] = dz;
            if (dz && (o < lo || o > hi))
            begin
                data_next.side.miss = 1'b1;
            end
            data_next.side.neg[2*a]   = d1[CoordW+1] ^ dir[a][CoordW-1];
            data_next.side.neg[2*a+1] = d2[CoordW+1] ^ dir[a][CoordW-1];
            data_next.lane[2*a].num   = {m1[MagW-1:0], {FracW{1'b0}}};
            data_next.lane[2*a+1].num = {m2[MagW-1:0], {FracW{1'b0}}};
            data_next.lane[2*a].den   = dm;
            data_next.lane[2*a+1].den = dm;
        end
    end

    assign up_ready = !valid_reg || dn_ready;
    assign dn_valid = valid_reg;
    assign dn_data  = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
        begin
            data_reg <= data_next;
        end
    end

endmodule

// ----- src/rayaabb_cell.sv -----
// One restoring-division step (one quotient bit) for all six lanes.
module rayaabb_cell import rayaabb_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic up_valid,
    output logic up_ready,
    input  div_t up_data,
    output logic dn_valid,
    input  logic dn_ready,
    output div_t dn_data
);

    logic valid_reg;
    div_t data_reg;
    div_t data_next;

    always_comb
    begin
        logic [CoordW:0] r2;
        logic [CoordW:0] rs;
        logic            ge;
        data_next = up_data;
        for (int l = 0; l < Lanes; l++)
        begin
            r2 = {up_data.lane[l].rem, up_data.lane[l].num[NumW-1]};
            ge = (r2 >= {1'b0, up_data.lane[l].den});
            rs = ge ? r2 - {1'b0, up_data.lane[l].den} : r2;
            data_next.lane[l].rem = rs[CoordW-1:0];
            data_next.lane[l].num = {up_data.lane[l].num[NumW-2:0], 1'b0};
            data_next.lane[l].quo = {up_data.lane[l].quo[NumW-2:0], ge};
        end
    end

    assign up_ready = !valid_reg || dn_ready;
    assign dn_valid = valid_reg;
    assign dn_data  = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
        begin
            data_reg <= data_next;
        end
    end

endmodule

// ----- src/rayaabb_round.sv -----
// Round half away from zero, apply sign, saturate to Q16.16.
module rayaabb_round import rayaabb_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic up_valid,
    output logic up_ready,
    input  div_t up_data,
    output logic dn_valid,
    input  logic dn_ready,
    output rnd_t dn_data
);

    logic valid_reg;
    rnd_t data_reg;
    rnd_t data_next;

    always_comb
    begin
        logic          rb;
        logic [NumW:0] q1;
        logic [NumW:0] nq;
        data_next.side = up_data.side;
        data_next.t    = '0;
        for (int l = 0; l < Lanes; l++)
        begin
            rb = ({up_data.lane[l].rem, 1'b0} >= {1'b0, up_data.lane[l].den});
            q1 = {1'b0, up_data.lane[l].quo} + (NumW+1)'(rb);
            nq = ~q1 + (NumW+1)'(1);
            if (up_data.side.neg[l])
            begin
                data_next.t[l] = (q1 > NegLim) ? TMin : nq[CoordW-1:0];
            end
            else
            begin
                data_next.t[l] = (q1 > PosLim) ? TMax : q1[CoordW-1:0];
            end
        end
    end

    assign up_ready = !valid_reg || dn_ready;
    assign dn_valid = valid_reg;
    assign dn_data  = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
        begin
            data_reg <= data_next;
        end
    end

endmodule

// ----- src/rayaabb_merge.sv -----
// Order slab times per axis, reduce over axes, decide hit.
module rayaabb_merge import rayaabb_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic up_valid,
    output logic up_ready,
    input  rnd_t up_data,
    output logic dn_valid,
    input  logic dn_ready,
    output res_t dn_data
);

    logic valid_reg;
    res_t data_reg;
    res_t data_next;

    always_comb
    begin
        logic signed [CoordW-1:0] t1, t2, tlo, thi, nr, fr;
        nr = $signed(TMin);
        fr = $signed(TMax);
        for (int a = 0; a < Axes; a++)
        begin
            t1  = $signed(up_data.t[2*a]);
            t2  = $signed(up_data.t[2*a+1]);
            tlo = (t1 < t2) ? t1 : t2;
            thi = (t1 < t2) ? t2 : t1;
            if (!up_data.side.skip[a])
            begin
                if (tlo > nr)
                begin
                    nr = tlo;
                end
                if (thi < fr)
                begin
                    fr = thi;
                end
            end
        end
        data_next.t_near = nr;
        data_next.t_far  = fr;
        data_next.hit    = !up_data.side.miss && (nr <= fr) && !fr[CoordW-1];
    end

    assign up_ready = !valid_reg || dn_ready;
    assign dn_valid = valid_reg;
    assign dn_data  = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
        begin
            data_reg <= data_next;
        end
    end

endmodule

// ----- src/ray_aabb_slab_test.sv -----
// Ray versus axis-aligned box, slab test, signed Q16.16.
// Input channel ray/ray_valid/ray_stall: one transaction carries origin,
// direction, box centre and half extents. Output channel res/res_valid/
// res_stall: one transaction per input with hit, t_near and t_far.
// Path from input transaction to res_valid: one setup stage,
// 49 division cells, one rounding stage, one merge/output stage.
// Throughput: one transaction per cycle while res_stall is low; each stage of
// the cell chain holds one item and hands it on every cycle unless stalled.
// Every stage has its own valid flag and moves whenever the next stage is
// empty or moving, so bubbles close up: while res_stall holds, items keep
// entering until the chain is full, then ray_stall rises.
// Reset clears all valid flags; the block takes input right after reset.
// Zero direction on an axis: no limit from that axis; origin outside the
// slab forces a miss. Times saturate to the Q16.16 range.
`include "assert_macros.svh"

module ray_aabb_slab_test import rayaabb_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic ray_valid,
    output logic ray_stall,
    input  ray_t ray,
    output logic res_valid,
    input  logic res_stall,
    output res_t res
);

    // chain index k feeds division cell k
    div_t chain_data  [NumW+1];
    logic chain_valid [NumW+1];
    logic chain_ready [NumW+1];

    rnd_t rnd_data;
    logic rnd_valid;
    logic rnd_ready;
    logic prep_ready;

    assign ray_stall = !prep_ready;

    rayaabb_prep u_prep (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (ray_valid),
        .up_ready (prep_ready),
        .up_data  (ray),
        .dn_valid (chain_valid[0]),
        .dn_ready (chain_ready[0]),
        .dn_data  (chain_data[0])
    );

    for (genvar k = 0; k < NumW; k++)
    begin : g_cell
        rayaabb_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .up_valid (chain_valid[k]),
            .up_ready (chain_ready[k]),
            .up_data  (chain_data[k]),
            .dn_valid (chain_valid[k+1]),
            .dn_ready (chain_ready[k+1]),
            .dn_data  (chain_data[k+1])
        );
    end

    rayaabb_round u_round (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (chain_valid[NumW]),
        .up_ready (chain_ready[NumW]),
        .up_data  (chain_data[NumW]),
        .dn_valid (rnd_valid),
        .dn_ready (rnd_ready),
        .dn_data  (rnd_data)
    );

    rayaabb_merge u_merge (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (rnd_valid),
        .up_ready (rnd_ready),
        .up_data  (rnd_data),
        .dn_valid (res_valid),
        .dn_ready (!res_stall),
        .dn_data  (res)
    );

    // empty output stage means the whole chain can move
    `ASSERT_IMPLY(a_empty_no_stall, !res_valid, !ray_stall, "input stalled with empty output")
    `ASSERT_IMPLY(a_hit_order, res_valid && res.hit, res.t_near <= res.t_far,
                  "hit with t_near above t_far")
    `ASSERT_IMPLY(a_hit_ahead, res_valid && res.hit, !res.t_far[CoordW-1],
                  "hit with negative t_far")

endmodule

// ----- tb/tb_ray_aabb_slab_test.sv -----
`timescale 1ns / 1ps

// Ray/box slab-test bench: directed corner cases, then random rays that
// are mostly aimed near the box, checked against an in-bench predictor.
module tb_ray_aabb_slab_test;
    import rayaabb_pkg::*;

    localparam longint TPos = 64'sd2147483647;
    localparam longint TNeg = -64'sd2147483648;

    logic clk;
    logic rst_n;
    logic ray_valid;
    logic ray_stall;
    ray_t ray;
    logic res_valid;
    logic res_stall;
    res_t res;

    res_t expected_q[$];     // predicted results, oldest first
    int   n_errors;
    bit   send_idle_en;      // random gaps on the input side
    bit   recv_idle_en;      // random stalls on the output side
    int   hold_off_cycles;   // long output stall request, served in its own process

    ray_aabb_slab_test i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .ray_valid (ray_valid),
        .ray_stall (ray_stall),
        .ray       (ray),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Time for one slab plane: (diff << 16) / dir, rounded half away
    // from zero, saturated to the 32-bit range.
    function automatic longint slab_time(longint diff, longint dir);
        logic [127:0] num;
        logic [127:0] den;
        logic [127:0] q;
        logic [127:0] r;
        bit           neg;
        begin
            num = 128'(diff < 0 ? -diff : diff) << 16;
            den = 128'(dir < 0 ? -dir : dir);
            q   = num / den;
            r   = num % den;
            neg = (diff < 0) != (dir < 0);
            if (r >= den - r)
                q = q + 1;
            if (neg)
                return (q > 128'(-TNeg)) ? TNeg : -longint'(q);
            return (q > 128'(TPos)) ? TPos : longint'(q);
        end
    endfunction

    function automatic res_t predict_hit(ray_t r);
        longint org[3];
        longint dir[3];
        longint ctr[3];
        longint half[3];
        longint lo, hi, t1, t2, near_t, far_t;
        bit     miss;
        res_t   o;
        begin
            org  = '{r.ray_org_x, r.ray_org_y, r.ray_org_z};
            dir  = '{r.ray_dir_x, r.ray_dir_y, r.ray_dir_z};
            ctr  = '{r.box_ctr_x, r.box_ctr_y, r.box_ctr_z};
            half = '{longint'({1'b0, r.box_half_x}), longint'({1'b0, r.box_half_y}),
                     longint'({1'b0, r.box_half_z})};
            near_t = TNeg;
            far_t  = TPos;
            miss   = 1'b0;
            for (int a = 0; a < 3; a++)
            begin
                lo = ctr[a] - half[a];
                hi = ctr[a] + half[a];
                if (dir[a] == 0)
                begin
                    if (org[a] < lo || org[a] > hi)
                        miss = 1'b1;
                end
                else
                begin
                    t1 = slab_time(lo - org[a], dir[a]);
                    t2 = slab_time(hi - org[a], dir[a]);
                    if ((t1 < t2 ? t1 : t2) > near_t)
                        near_t = t1 < t2 ? t1 : t2;
                    if ((t1 < t2 ? t2 : t1) < far_t)
                        far_t = t1 < t2 ? t2 : t1;
                end
            end
            o.hit    = !miss && near_t <= far_t && far_t >= 0;
            o.t_near = near_t[31:0];
            o.t_far  = far_t[31:0];
            return o;
        end
    endfunction

    // Send one transaction; valid stays high across back-to-back sends
    // and drops only for an idle gap or when the sender waits to drain.
    task automatic send_ray(ray_t r);
        begin
            if (send_idle_en && $urandom_range(0, 5) == 0)
            begin
                ray_valid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge clk);
            end
            ray_valid <= 1'b1;
            ray       <= r;
            expected_q.push_back(predict_hit(r));
            @(posedge clk);
            while (ray_stall)
                @(posedge clk);
        end
    endtask

    task automatic wait_drained();
        begin
            ray_valid <= 1'b0;
            while (expected_q.size() != 0)
                @(posedge clk);
        end
    endtask

    // Every field set to one pattern; half extents take its low bits.
    function automatic ray_t fill_ray(logic [31:0] w);
        ray_t r;
        begin
            r.ray_org_x  = w;
            r.ray_org_y  = w;
            r.ray_org_z  = w;
            r.ray_dir_x  = w;
            r.ray_dir_y  = w;
            r.ray_dir_z  = w;
            r.box_ctr_x  = w;
            r.box_ctr_y  = w;
            r.box_ctr_z  = w;
            r.box_half_x = w[30:0];
            r.box_half_y = w[30:0];
            r.box_half_z = w[30:0];
            return r;
        end
    endfunction

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'($signed($urandom_range(0, 20 << 16)) - (10 << 16));
            3: return 32'($signed($urandom_range(0, 8)) - 4) << 16;
            default: return $urandom;
        endcase
    endfunction

    // Random ray, mostly aimed roughly at a nearby box.
    function automatic ray_t rand_ray();
        ray_t         r;
        logic [383:0] raw;
        begin
            raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                   $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
            r = raw[$bits(ray_t)-1:0];
            if ($urandom_range(0, 3) != 0)
            begin
                r.ray_org_x  = rand_coord();
                r.ray_org_y  = rand_coord();
                r.ray_org_z  = rand_coord();
                r.ray_dir_x  = ($urandom_range(0, 5) == 0) ? 0 : rand_coord();
                r.ray_dir_y  = ($urandom_range(0, 5) == 0) ? 0 : rand_coord();
                r.ray_dir_z  = ($urandom_range(0, 5) == 0) ? 0 : rand_coord();
                r.box_ctr_x  = rand_coord();
                r.box_ctr_y  = rand_coord();
                r.box_ctr_z  = rand_coord();
                r.box_half_x = ($urandom_range(0, 3) == 0) ? 31'($urandom)
                                                           : 31'($urandom_range(0, 8 << 16));
                r.box_half_y = ($urandom_range(0, 3) == 0) ? 31'($urandom)
                                                           : 31'($urandom_range(0, 8 << 16));
                r.box_half_z = ($urandom_range(0, 3) == 0) ? 31'($urandom)
                                                           : 31'($urandom_range(0, 8 << 16));
            end
            return r;
        end
    endfunction

    task automatic test_directed();
        ray_t r;
        begin
            // Unit box at origin, ray along +x from x = -5: clean hit.
            r = '0;
            r.ray_org_x = -(5 << 16);
            r.ray_dir_x = 1 << 16;
            r.box_half_x = 31'(1 << 16); r.box_half_y = 31'(1 << 16);
            r.box_half_z = 31'(1 << 16);
            send_ray(r);
            // Same ray pointing away: box behind origin.
            r.ray_dir_x = -(1 << 16);
            send_ray(r);
            // All-zero direction, origin inside: hit with both extremes.
            r.ray_org_x = 0; r.ray_dir_x = 0;
            send_ray(r);
            // Zero direction, origin exactly on the slab face (inclusive).
            r.ray_org_y = 1 << 16;
            send_ray(r);
            // Zero direction, origin outside a slab: forced miss.
            r.ray_org_y = (1 << 16) + 1;
            send_ray(r);
            // Zero-size box hit exactly at the origin.
            r = '0;
            r.ray_dir_z = 1;
            send_ray(r);
            // Tiny direction: times saturate both ways.
            r = '0;
            r.ray_org_x = 32'h8000_0000; r.ray_dir_x = 1;
            r.box_ctr_x = 32'h7fff_ffff; r.box_half_x = 31'h7fff_ffff;
            send_ray(r);
            r.ray_dir_x = -1;
            send_ray(r);
            // Extremes of every field, all ones and all zeros.
            r = '1;
            send_ray(r);
            r = '0;
            send_ray(r);
            r = fill_ray(32'h8000_0000);
            send_ray(r);
            r = fill_ray(32'h7fff_ffff);
            send_ray(r);
            // Rounding ties: diff 1 over dir 2^17 gives exactly half an lsb.
            r = '0;
            r.ray_dir_x = 1 << 17; r.box_ctr_x = 1; r.ray_dir_y = -(1 << 17);
            r.box_ctr_y = 3;
            send_ray(r);
            // Most negative direction.
            r.ray_dir_x = 32'h8000_0000; r.box_half_x = 31'h7fff_ffff;
            send_ray(r);
            wait_drained();
        end
    endtask

    task automatic test_random(int n);
        begin
            for (int i = 0; i < n; i++)
                send_ray(rand_ray());
        end
    endtask

    // Output stalls long enough for the pipe to fill and push back on input.
    task automatic test_backpressure();
        begin
            hold_off_cycles = 120;
            test_random(80);
            wait_drained();
            // Sender pauses with everything delivered, then resumes.
            test_random(20);
            wait_drained();
        end
    endtask

    // Output side: stall generation and in-order comparison.
    initial
    begin
        res_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_off_cycles > 0)
            begin
                res_stall <= 1'b1;
                repeat (hold_off_cycles) @(posedge clk);
                hold_off_cycles = 0;
                res_stall <= 1'b0;
            end
            else if (recv_idle_en && !res_stall && $urandom_range(0, 5) == 0)
            begin
                res_stall <= 1'b1;
                repeat ($urandom_range(1, 6)) @(posedge clk);
                res_stall <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        res_t e;
        if (rst_n && res_valid && !res_stall)
        begin
            if (expected_q.size() == 0)
            begin
                $display("%0t: unexpected transaction, actual %h", $time, res);
                n_errors++;
            end
            else
            begin
                e = expected_q.pop_front();
                if (e.hit !== res.hit)
                begin
                    $display("%0t: hit expected %b actual %b", $time, e.hit, res.hit);
                    n_errors++;
                end
                if (e.t_near !== res.t_near)
                begin
                    $display("%0t: t_near expected %h actual %h", $time, e.t_near, res.t_near);
                    n_errors++;
                end
                if (e.t_far !== res.t_far)
                begin
                    $display("%0t: t_far expected %h actual %h", $time, e.t_far, res.t_far);
                    n_errors++;
                end
            end
        end
    end

    initial
    begin
        #2000000;
        $display("tb_ray_aabb_slab_test: FAIL");
        $finish;
    end

    initial
    begin
        rst_n           = 1'b0;
        ray_valid       = 1'b0;
        ray             = '0;
        n_errors        = 0;
        send_idle_en    = 1'b0;
        recv_idle_en    = 1'b0;
        hold_off_cycles = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        send_idle_en = 1'b1;
        recv_idle_en = 1'b1;
        test_random(400);
        test_backpressure();
        // Last stretch at full rate with no idling.
        send_idle_en = 1'b0;
        recv_idle_en = 1'b0;
        test_random(100);
        wait_drained();
        repeat (60) @(posedge clk);

        if (n_errors == 0)
            $display("tb_ray_aabb_slab_test: PASS");
        else
            $display("tb_ray_aabb_slab_test: FAIL");
        $finish;
    end
endmodule
